### hdl/edcp_pkg.sv
// ----------------------------------------------------------------------------
// edcp_pkg: shared types and constants of the descriptor chain parser
// Parse phases, result kinds, descriptor tags and the result record.
// ----------------------------------------------------------------------------
package edcp_pkg;

   localparam int unsigned BodyLenWidth = 24;
   localparam int unsigned DescLenWidth = 28;

   typedef enum logic [3:0] {
      PH_TAG       = 4'd0,
      PH_LEN       = 4'd1,
      PH_DROP      = 4'd2,
      PH_ES_ID     = 4'd3,
      PH_ES_FLAGS  = 4'd4,
      PH_ES_DEP    = 4'd5,
      PH_ES_URLLEN = 4'd6,
      PH_ES_URL    = 4'd7,
      PH_ES_OCR    = 4'd8,
      PH_DEC       = 4'd9,
      PH_PAYLOAD   = 4'd10
   } phase_type;

   typedef enum logic [2:0] {
      KIND_HEADER  = 3'd0,
      KIND_ES      = 3'd1,
      KIND_DEC     = 3'd2,
      KIND_PAYLOAD = 3'd3,
      KIND_UNKNOWN = 3'd4,
      KIND_OVERRUN = 3'd5,
      KIND_END     = 3'd6
   } kind_type;

   // how far the optional parts of an ES descriptor have gone
   typedef enum logic [1:0] {
      ES_STAGE_FLAGS = 2'd0,
      ES_STAGE_DEP   = 2'd1,
      ES_STAGE_URL   = 2'd2,
      ES_STAGE_OCR   = 2'd3
   } es_stage_type;

   localparam logic [7:0] TAG_OD  = 8'd1;
   localparam logic [7:0] TAG_IOD = 8'd2;
   localparam logic [7:0] TAG_ES  = 8'd3;
   localparam logic [7:0] TAG_DEC = 8'd4;
   localparam logic [7:0] TAG_SL  = 8'd6;

   localparam logic [7:0] ES_FLAG_DEP = 8'h80;
   localparam logic [7:0] ES_FLAG_URL = 8'h40;
   localparam logic [7:0] ES_FLAG_OCR = 8'h20;

   localparam logic [7:0] LEN_GROUP_MASK = 8'h7f;
   localparam logic [1:0] LEN_MAX_MORE   = 2'd3;

   localparam logic [7:0] OD_DROP_SKIP  = 8'd2;
   localparam logic [7:0] IOD_SKIP      = 8'd7;
   localparam logic [7:0] ES_DEP_SKIP   = 8'd2;
   localparam logic [7:0] ES_OCR_SKIP   = 8'd2;
   localparam logic [3:0] ES_ID_BYTES   = 4'd2;
   localparam logic [3:0] DEC_LAST_IDX  = 4'd12;
   localparam logic [3:0] DEC_HI_FIRST  = 4'd5;

   typedef struct packed {
      logic [7:0] data_in;
      logic       first;
   } req_item_type;

   typedef struct packed {
      kind_type                  kind;
      logic [7:0]                tag;
      logic [DescLenWidth-1:0]   desc_length;
      logic [15:0]               es_id;
      logic [7:0]                es_flags;
      logic [7:0]                object_type;
      logic [7:0]                stream_type;
      logic [23:0]               buffer_size;
      logic [31:0]               max_bitrate;
      logic [31:0]               avg_bitrate;
      logic [7:0]                payload_byte;
      logic                      body_end;
   } rsp_fields_type;

   // next phase after a part of an ES descriptor, from the flags byte
   function automatic phase_type es_after(es_stage_type stage, logic [7:0] fl);
      phase_type ph;
      if (stage < ES_STAGE_DEP && (fl & ES_FLAG_DEP) != 8'd0) begin
         ph = PH_ES_DEP;
      end else if (stage < ES_STAGE_URL && (fl & ES_FLAG_URL) != 8'd0) begin
         ph = PH_ES_URLLEN;
      end else if (stage < ES_STAGE_OCR && (fl & ES_FLAG_OCR) != 8'd0) begin
         ph = PH_ES_OCR;
      end else begin
         ph = PH_TAG;
      end
      return ph;
   endfunction

endpackage

### hdl/edcp_ifs.sv
// ----------------------------------------------------------------------------
// edcp_ifs: channel interfaces of the descriptor chain parser
// Body byte channel, result channel and body length write channel.
// ----------------------------------------------------------------------------
interface edcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_in;
   logic       first;

   modport source (output valid, output data_in, output first, input ready);
   modport sink   (input valid, input data_in, input first, output ready);
endinterface

interface edcp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [2:0]                           kind;
   logic [7:0]                           tag;
   logic [edcp_pkg::DescLenWidth-1:0]    desc_length;
   logic [15:0]                          es_id;
   logic [7:0]                           es_flags;
   logic [7:0]                           object_type;
   logic [7:0]                           stream_type;
   logic [23:0]                          buffer_size;
   logic [31:0]                          max_bitrate;
   logic [31:0]                          avg_bitrate;
   logic [7:0]                           payload_byte;
   logic                                 body_end;

   modport source (output valid, output kind, output tag, output desc_length,
                   output es_id, output es_flags, output object_type,
                   output stream_type, output buffer_size, output max_bitrate,
                   output avg_bitrate, output payload_byte, output body_end,
                   input ready);
   modport sink   (input valid, input kind, input tag, input desc_length,
                   input es_id, input es_flags, input object_type,
                   input stream_type, input buffer_size, input max_bitrate,
                   input avg_bitrate, input payload_byte, input body_end,
                   output ready);
endinterface

interface edcp_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [edcp_pkg::BodyLenWidth-1:0]    body_length;

   modport source (output valid, output body_length, input ready);
   modport sink   (input valid, input body_length, output ready);
endinterface

### hdl/edcp_in_stage.sv
// ----------------------------------------------------------------------------
// edcp_in_stage: input register
// Holds one body byte until the parser takes it.
// ----------------------------------------------------------------------------
module edcp_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   edcp_req_if.sink               req,
   input  logic                   advance,
   output logic                   item_valid,
   output edcp_pkg::req_item_type item
);

   logic                   valid_ff;
   logic                   valid_in;
   edcp_pkg::req_item_type item_ff;
   logic                   take;

   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.data_in <= req.data_in;
         item_ff.first   <= req.first;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### hdl/edcp_parser.sv
// ----------------------------------------------------------------------------
// edcp_parser: descriptor chain state machine
// Steps the parse state by one body byte and forms the result for it.
// ----------------------------------------------------------------------------
module edcp_parser (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    step,
   input  edcp_pkg::req_item_type                  item,
   input  logic [edcp_pkg::BodyLenWidth-1:0]       body_length,
   output logic                                    res_valid,
   output edcp_pkg::rsp_fields_type                res
);

   localparam int unsigned BW = edcp_pkg::BodyLenWidth;
   localparam int unsigned DW = edcp_pkg::DescLenWidth;

   edcp_pkg::phase_type phase_ff, phase_in, phase_eff;
   logic [BW-1:0]       pos_ff, pos_in, pos_eff;
   logic [7:0]          tag_ff, tag_in, tag_eff;
   logic [DW-1:0]       acc_ff, acc_in, acc_eff;
   logic [1:0]          seen_ff, seen_in, seen_eff;
   logic [DW-1:0]       rem_ff, rem_in, rem_eff;
   logic [3:0]          fidx_ff, fidx_in, fidx_eff;
   logic [7:0]          skip_ff, skip_in, skip_eff;
   logic [39:0]         held0_ff, held0_in, held0_eff;
   logic [63:0]         held1_ff, held1_in, held1_eff;
   logic                stop_ff, stop_in, stop_eff;

   logic [7:0]    b;
   logic          in_body;
   logic          last;
   logic          bad_tag;
   logic          len_more;
   logic [DW-1:0] acc_new;
   logic [DW-1:0] rem_dec;
   logic [7:0]    skip_dec;
   logic [2:0]    dec_need;
   logic          ovr;
   logic [63:0]   held1_dec;
   edcp_pkg::es_stage_type skip_stage;

   // a first byte restarts from the cleared state
   always_comb begin
      if (item.first) begin
         phase_eff = edcp_pkg::PH_TAG;
         pos_eff   = '0;
         tag_eff   = '0;
         acc_eff   = '0;
         seen_eff  = '0;
         rem_eff   = '0;
         fidx_eff  = '0;
         skip_eff  = '0;
         held0_eff = '0;
         held1_eff = '0;
         stop_eff  = 1'b0;
      end else begin
         phase_eff = phase_ff;
         pos_eff   = pos_ff;
         tag_eff   = tag_ff;
         acc_eff   = acc_ff;
         seen_eff  = seen_ff;
         rem_eff   = rem_ff;
         fidx_eff  = fidx_ff;
         skip_eff  = skip_ff;
         held0_eff = held0_ff;
         held1_eff = held1_ff;
         stop_eff  = stop_ff;
      end
   end

   assign b        = item.data_in;
   assign in_body  = pos_eff < body_length;
   assign last     = ({1'b0, pos_eff} + {{BW{1'b0}}, 1'b1}) == {1'b0, body_length};
   assign bad_tag  = (b == 8'd0) || (b > edcp_pkg::TAG_SL);
   assign len_more = b[7] && (seen_eff < edcp_pkg::LEN_MAX_MORE);
   // shift in the low seven bits of the length group
   assign acc_new  = {acc_eff[DW-8:0], b[6:0]};
   assign rem_dec  = (rem_eff != '0) ? rem_eff - {{(DW-1){1'b0}}, 1'b1} : rem_eff;
   assign skip_dec = (skip_eff != 8'd0) ? skip_eff - 8'd1 : skip_eff;
   assign held1_dec = {held1_eff[55:0], b};

   always_comb begin
      case (fidx_eff)
         4'd0, 4'd1: dec_need = 3'd1;
         4'd2:       dec_need = 3'd3;
         4'd5, 4'd9: dec_need = 3'd4;
         default:    dec_need = 3'd0;
      endcase
   end

   always_comb begin
      ovr = 1'b0;
      if (phase_eff == edcp_pkg::PH_ES_ID) begin
         ovr = (fidx_eff == 4'd0) && (rem_eff < DW'(2));
      end else if (phase_eff == edcp_pkg::PH_ES_FLAGS) begin
         ovr = (rem_eff == '0);
      end else if (phase_eff == edcp_pkg::PH_DEC) begin
         ovr = (dec_need != 3'd0) && (rem_eff < DW'(dec_need));
      end
   end

   always_comb begin
      case (phase_eff)
         edcp_pkg::PH_ES_DEP: skip_stage = edcp_pkg::ES_STAGE_DEP;
         edcp_pkg::PH_ES_URL: skip_stage = edcp_pkg::ES_STAGE_URL;
         default:             skip_stage = edcp_pkg::ES_STAGE_OCR;
      endcase
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      tag_in   = tag_ff;
      acc_in   = acc_ff;
      seen_in  = seen_ff;
      rem_in   = rem_ff;
      fidx_in  = fidx_ff;
      skip_in  = skip_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      stop_in  = stop_ff;
      if (step) begin
         phase_in = phase_eff;
         pos_in   = pos_eff;
         tag_in   = tag_eff;
         acc_in   = acc_eff;
         seen_in  = seen_eff;
         rem_in   = rem_eff;
         fidx_in  = fidx_eff;
         skip_in  = skip_eff;
         held0_in = held0_eff;
         held1_in = held1_eff;
         stop_in  = stop_eff;
         if (in_body) begin
            pos_in = pos_eff + {{(BW-1){1'b0}}, 1'b1};
            if (!stop_eff) begin
               unique case (phase_eff)
                  edcp_pkg::PH_TAG: begin
                     if (last) begin
                        stop_in = 1'b1;
                     end else begin
                        tag_in = b;
                        if (bad_tag) begin
                           stop_in = 1'b1;
                        end else begin
                           acc_in   = '0;
                           seen_in  = '0;
                           phase_in = edcp_pkg::PH_LEN;
                        end
                     end
                  end
                  edcp_pkg::PH_LEN: begin
                     acc_in = acc_new;
                     if (len_more) begin
                        seen_in = seen_eff + 2'd1;
                     end else begin
                        rem_in   = acc_new;
                        fidx_in  = '0;
                        held0_in = '0;
                        held1_in = '0;
                        case (tag_eff)
                           edcp_pkg::TAG_OD: begin
                              if (acc_new >= DW'(2)) begin
                                 phase_in = edcp_pkg::PH_DROP;
                                 skip_in  = edcp_pkg::OD_DROP_SKIP;
                              end else begin
                                 phase_in = edcp_pkg::PH_TAG;
                              end
                           end
                           edcp_pkg::TAG_IOD: begin
                              phase_in = edcp_pkg::PH_DROP;
                              skip_in  = edcp_pkg::IOD_SKIP;
                           end
                           edcp_pkg::TAG_ES:  phase_in = edcp_pkg::PH_ES_ID;
                           edcp_pkg::TAG_DEC: phase_in = edcp_pkg::PH_DEC;
                           default: begin
                              phase_in = (acc_new == '0) ? edcp_pkg::PH_TAG
                                                         : edcp_pkg::PH_PAYLOAD;
                           end
                        endcase
                     end
                  end
                  edcp_pkg::PH_DROP: begin
                     rem_in  = rem_dec;
                     skip_in = skip_dec;
                     if (skip_dec == 8'd0) begin
                        phase_in = edcp_pkg::PH_TAG;
                     end
                  end
                  edcp_pkg::PH_ES_ID: begin
                     if (ovr) begin
                        stop_in = 1'b1;
                     end else begin
                        rem_in   = rem_dec;
                        held0_in = {24'd0, held0_eff[7:0], b};
                        fidx_in  = fidx_eff + 4'd1;
                        if (fidx_eff + 4'd1 >= edcp_pkg::ES_ID_BYTES) begin
                           phase_in = edcp_pkg::PH_ES_FLAGS;
                        end
                     end
                  end
                  edcp_pkg::PH_ES_FLAGS: begin
                     if (ovr) begin
                        stop_in = 1'b1;
                     end else begin
                        rem_in   = rem_dec;
                        held1_in = {56'd0, b};
                        phase_in = edcp_pkg::es_after(edcp_pkg::ES_STAGE_FLAGS, b);
                        if (phase_in == edcp_pkg::PH_ES_DEP) begin
                           skip_in = edcp_pkg::ES_DEP_SKIP;
                        end else if (phase_in == edcp_pkg::PH_ES_OCR) begin
                           skip_in = edcp_pkg::ES_OCR_SKIP;
                        end
                     end
                  end
                  edcp_pkg::PH_ES_DEP, edcp_pkg::PH_ES_URL, edcp_pkg::PH_ES_OCR: begin
                     rem_in  = rem_dec;
                     skip_in = skip_dec;
                     if (skip_dec == 8'd0) begin
                        phase_in = edcp_pkg::es_after(skip_stage, held1_eff[7:0]);
                        if (phase_in == edcp_pkg::PH_ES_OCR) begin
                           skip_in = edcp_pkg::ES_OCR_SKIP;
                        end
                     end
                  end
                  edcp_pkg::PH_ES_URLLEN: begin
                     rem_in = rem_dec;
                     if (b == 8'd0) begin
                        phase_in = edcp_pkg::es_after(edcp_pkg::ES_STAGE_URL,
                                                      held1_eff[7:0]);
                        if (phase_in == edcp_pkg::PH_ES_OCR) begin
                           skip_in = edcp_pkg::ES_OCR_SKIP;
                        end
                     end else begin
                        skip_in  = b;
                        phase_in = edcp_pkg::PH_ES_URL;
                     end
                  end
                  edcp_pkg::PH_DEC: begin
                     if (ovr) begin
                        stop_in = 1'b1;
                     end else begin
                        rem_in = rem_dec;
                        if (fidx_eff < edcp_pkg::DEC_HI_FIRST) begin
                           held0_in = {held0_eff[31:0], b};
                        end else begin
                           held1_in = held1_dec;
                        end
                        if (fidx_eff < edcp_pkg::DEC_LAST_IDX) begin
                           fidx_in = fidx_eff + 4'd1;
                        end else begin
                           phase_in = edcp_pkg::PH_TAG;
                        end
                     end
                  end
                  edcp_pkg::PH_PAYLOAD: begin
                     rem_in = rem_dec;
                     if (rem_dec == '0) begin
                        phase_in = edcp_pkg::PH_TAG;
                     end
                  end
                  default: phase_in = edcp_pkg::PH_TAG;
               endcase
            end
         end
      end
   end

   // result for the byte in hand
   always_comb begin
      logic got;
      got = 1'b0;
      res = '0;
      res.tag         = tag_eff;
      res.desc_length = acc_eff;
      if (in_body && !stop_eff) begin
         unique case (phase_eff)
            edcp_pkg::PH_TAG: begin
               if (!last && bad_tag) begin
                  got             = 1'b1;
                  res.kind        = edcp_pkg::KIND_UNKNOWN;
                  res.tag         = b;
                  res.desc_length = '0;
               end
            end
            edcp_pkg::PH_LEN: begin
               if (!len_more) begin
                  got             = 1'b1;
                  res.kind        = edcp_pkg::KIND_HEADER;
                  res.desc_length = acc_new;
               end
            end
            edcp_pkg::PH_ES_ID: begin
               if (ovr) begin
                  got      = 1'b1;
                  res.kind = edcp_pkg::KIND_OVERRUN;
               end
            end
            edcp_pkg::PH_ES_FLAGS: begin
               got = 1'b1;
               if (ovr) begin
                  res.kind = edcp_pkg::KIND_OVERRUN;
               end else begin
                  res.kind     = edcp_pkg::KIND_ES;
                  res.es_id    = held0_eff[15:0];
                  res.es_flags = b;
               end
            end
            edcp_pkg::PH_DEC: begin
               if (ovr) begin
                  got      = 1'b1;
                  res.kind = edcp_pkg::KIND_OVERRUN;
               end else if (fidx_eff == edcp_pkg::DEC_LAST_IDX) begin
                  got             = 1'b1;
                  res.kind        = edcp_pkg::KIND_DEC;
                  res.object_type = held0_eff[39:32];
                  res.stream_type = held0_eff[31:24];
                  res.buffer_size = held0_eff[23:0];
                  res.max_bitrate = held1_dec[63:32];
                  res.avg_bitrate = held1_dec[31:0];
               end
            end
            edcp_pkg::PH_PAYLOAD: begin
               got              = 1'b1;
               res.kind         = edcp_pkg::KIND_PAYLOAD;
               res.payload_byte = b;
            end
            default: got = 1'b0;
         endcase
      end
      if (!got) begin
         res      = '0;
         res.kind = edcp_pkg::KIND_END;
      end
      res.body_end = last;
      res_valid    = in_body && (got || last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= edcp_pkg::PH_TAG;
         pos_ff   <= '0;
         tag_ff   <= '0;
         acc_ff   <= '0;
         seen_ff  <= '0;
         rem_ff   <= '0;
         fidx_ff  <= '0;
         skip_ff  <= '0;
         held0_ff <= '0;
         held1_ff <= '0;
         stop_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         tag_ff   <= tag_in;
         acc_ff   <= acc_in;
         seen_ff  <= seen_in;
         rem_ff   <= rem_in;
         fidx_ff  <= fidx_in;
         skip_ff  <= skip_in;
         held0_ff <= held0_in;
         held1_ff <= held1_in;
         stop_ff  <= stop_in;
      end
   end

`ifndef SYNTH
   a_fidx_range: assert property (@(posedge clock) disable iff (reset)
      fidx_ff <= edcp_pkg::DEC_LAST_IDX)
      else $error("field index past last decoder config byte");

   a_stopped_end_only: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && stop_eff |-> res.kind == edcp_pkg::KIND_END)
      else $error("stopped chain gave a result other than end only");

   a_end_only_last: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && res.kind == edcp_pkg::KIND_END |-> res.body_end)
      else $error("end-only result on a byte that is not the last");

   a_pos_hold_beyond: assert property (@(posedge clock) disable iff (reset)
      step && !item.first && pos_ff >= body_length |=> $stable(pos_ff))
      else $error("body position moved past the body end");
`endif

endmodule

### hdl/edcp_out_stage.sv
// ----------------------------------------------------------------------------
// edcp_out_stage: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module edcp_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  logic                      res_valid,
   input  edcp_pkg::rsp_fields_type  res,
   output logic                      can_load,
   edcp_rsp_if.source                rsp
);

   logic                     valid_ff;
   logic                     valid_in;
   edcp_pkg::rsp_fields_type res_ff;

   assign can_load = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = res_valid;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.kind         = res_ff.kind;
   assign rsp.tag          = res_ff.tag;
   assign rsp.desc_length  = res_ff.desc_length;
   assign rsp.es_id        = res_ff.es_id;
   assign rsp.es_flags     = res_ff.es_flags;
   assign rsp.object_type  = res_ff.object_type;
   assign rsp.stream_type  = res_ff.stream_type;
   assign rsp.buffer_size  = res_ff.buffer_size;
   assign rsp.max_bitrate  = res_ff.max_bitrate;
   assign rsp.avg_bitrate  = res_ff.avg_bitrate;
   assign rsp.payload_byte = res_ff.payload_byte;
   assign rsp.body_end     = res_ff.body_end;

endmodule

### hdl/es_descriptor_chain_parser_core.sv
// ----------------------------------------------------------------------------
// es_descriptor_chain_parser_core: ES descriptor chain parser
// Walks the descriptor chain of a box body one byte per transfer and reports
// headers, ES fields, decoder config, payload bytes, chain errors and body ends.
// ----------------------------------------------------------------------------
//
//   channel    direction  transfer carries
//   ---------  ---------  -----------------------------------------------
//   req_chan   in         one body byte (data_in) and restart mark (first)
//   rsp_chan   out        one result record: kind, tag, lengths, fields
//   csr_chan   in         body_length write, always ready
//
// One byte per cycle sustained while rsp_chan does not stall; a result passes
// through the input register, then the result register.
// The parse step is one pass of the phase state machine between the two.
// Reset (synchronous) clears the parse and body_length to zero.
// A stall on rsp_chan fills the result register, then the input register,
// then drops req_chan.ready; bytes that give no result still wait their turn.
// ----------------------------------------------------------------------------
module es_descriptor_chain_parser_core (
   input  logic        clock,
   input  logic        reset,
   edcp_req_if.sink    req_chan,
   edcp_rsp_if.source  rsp_chan,
   edcp_csr_if.sink    csr_chan
);

   logic [edcp_pkg::BodyLenWidth-1:0] body_length_ff;
   logic [edcp_pkg::BodyLenWidth-1:0] body_length_in;

   logic                     item_valid;
   edcp_pkg::req_item_type   item;
   logic                     can_load;
   logic                     step;
   logic                     res_valid;
   edcp_pkg::rsp_fields_type res;

   // body length register: user writes only while the block is idle; unchecked
   assign csr_chan.ready = 1'b1;
   assign body_length_in = (csr_chan.valid) ? csr_chan.body_length : body_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         body_length_ff <= '0;
      end else begin
         body_length_ff <= body_length_in;
      end
   end

   // a held byte is parsed once its result (if any) has somewhere to go
   assign step = item_valid && can_load;

   edcp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .advance    (step),
      .item_valid (item_valid),
      .item       (item)
   );

   edcp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (item),
      .body_length (body_length_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   edcp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .res_valid (res_valid),
      .res       (res),
      .can_load  (can_load),
      .rsp       (rsp_chan)
   );

`ifndef SYNTH
   a_unknown_no_len: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.kind == edcp_pkg::KIND_UNKNOWN
      |-> rsp_chan.desc_length == '0)
      else $error("unknown tag result carries a length");

   a_end_only_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.kind == edcp_pkg::KIND_END
      |-> rsp_chan.body_end && rsp_chan.tag == 8'd0)
      else $error("end-only result not clean");

   a_no_step_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !step)
      else $error("parser stepped while result register was stalled");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for es_descriptor_chain_parser_core
// Feeds esds descriptor bodies byte by byte: a few hand-built bodies for the
// edge cases, a long result stall, then random chains, mostly under stalls.
// A cycle-free model of the parser predicts every result record, and each
// record leaving the block is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
   import edcp_pkg::*;

   // decoder specific info; the package has no constant for this tag
   localparam logic [7:0] TAG_DSI       = 8'd5;
   localparam logic [7:0] TAG_FORBIDDEN = 8'd0;
   // first byte of the average bitrate inside the decoder config fields
   localparam logic [3:0] DEC_AVG_FIRST = 4'd9;

   localparam int SETTLE_CYCLES = 6;     // input reg + result reg + margin
   localparam int STALL_LIMIT   = 2000;  // cycles without any transfer
   localparam int HOLD_CYCLES   = 150;   // long result stall
   localparam int MAX_REPORTS   = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   edcp_req_if req_if ();
   edcp_rsp_if rsp_if ();
   edcp_csr_if csr_if ();

   es_descriptor_chain_parser_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // ------------------------------------------------------------------------
   // Parser model state. Kept in step with the block by the scoreboard, one
   // call per accepted byte.
   // ------------------------------------------------------------------------
   logic [23:0] body_len_cfg;
   phase_type   p_phase;
   logic [23:0] p_pos;          // position inside the body
   logic [7:0]  p_tag;
   logic [27:0] p_len;          // decoded descriptor length
   logic [1:0]  p_len_groups;   // length groups seen with the more bit
   logic [27:0] p_left;         // descriptor bytes left
   logic [3:0]  p_field;        // fixed field byte index
   logic [7:0]  p_skip;
   logic [63:0] p_held0;
   logic [63:0] p_held1;
   bit          p_halted;       // chain stopped, only the end record remains

   rsp_fields_type pending_results[$];
   logic [7:0]     body_bytes[$];

   int sender_idle_pct = 0;
   int recv_idle_pct   = 0;
   bit rsp_hold        = 1'b0;
   int stall_cycles    = 0;

   int bytes_sent      = 0;
   int bodies_sent     = 0;
   int length_writes   = 0;
   int results_checked = 0;
   int failure_count   = 0;
   int kind_hits[7];

   function automatic void clear_parse_state();
      p_phase      = PH_TAG;
      p_pos        = '0;
      p_tag        = '0;
      p_len        = '0;
      p_len_groups = '0;
      p_left       = '0;
      p_field      = '0;
      p_skip       = '0;
      p_held0      = '0;
      p_held1      = '0;
      p_halted     = 1'b0;
   endfunction

   function automatic void use_desc_byte();
      if (p_left != '0) p_left = p_left - 1'b1;
   endfunction

   // pick the next optional part of an ES descriptor from its flags byte
   function automatic void advance_es_part(input es_stage_type done);
      logic [7:0] fl;
      fl = p_held1[7:0];
      if (done < ES_STAGE_DEP && (fl & ES_FLAG_DEP) != 8'd0) begin
         p_phase = PH_ES_DEP;
         p_skip  = ES_DEP_SKIP;
      end else if (done < ES_STAGE_URL && (fl & ES_FLAG_URL) != 8'd0) begin
         p_phase = PH_ES_URLLEN;
      end else if (done < ES_STAGE_OCR && (fl & ES_FLAG_OCR) != 8'd0) begin
         p_phase = PH_ES_OCR;
         p_skip  = ES_OCR_SKIP;
      end else begin
         p_phase = PH_TAG;
      end
   endfunction

   // field start with fewer descriptor bytes left than it needs
   function automatic bit field_overrun(input logic [27:0] need);
      if (p_left >= need) return 1'b0;
      p_halted = 1'b1;
      return 1'b1;
   endfunction

   // one byte through the phase machine; 1 when it reports something
   function automatic bit parse_desc_byte(input logic [7:0] b, inout rsp_fields_type r);
      logic [27:0] need;
      r.tag         = p_tag;
      r.desc_length = p_len;
      case (p_phase)
         PH_TAG: begin
            if ({1'b0, p_pos} + 25'd2 > {1'b0, body_len_cfg}) begin
               p_halted = 1'b1;
               return 1'b0;
            end
            p_tag = b;
            if (b < TAG_OD || b > TAG_SL) begin
               r.kind        = KIND_UNKNOWN;
               r.tag         = b;
               r.desc_length = '0;
               p_halted      = 1'b1;
               return 1'b1;
            end
            p_len        = '0;
            p_len_groups = '0;
            p_phase      = PH_LEN;
            return 1'b0;
         end
         PH_LEN: begin
            p_len = (p_len << 7) | 28'(b & LEN_GROUP_MASK);
            // a fourth group ends the length whatever its more bit says
            if (b[7] && p_len_groups < LEN_MAX_MORE) begin
               p_len_groups = p_len_groups + 1'b1;
               return 1'b0;
            end
            p_left  = p_len;
            p_field = '0;
            p_held0 = '0;
            p_held1 = '0;
            case (p_tag)
               TAG_OD: begin
                  if (p_len >= 28'd2) begin
                     p_phase = PH_DROP;
                     p_skip  = OD_DROP_SKIP;
                  end else begin
                     p_phase = PH_TAG;
                  end
               end
               TAG_IOD: begin
                  p_phase = PH_DROP;
                  p_skip  = IOD_SKIP;
               end
               TAG_ES:  p_phase = PH_ES_ID;
               TAG_DEC: p_phase = PH_DEC;
               default: p_phase = (p_len == '0) ? PH_TAG : PH_PAYLOAD;
            endcase
            r.kind        = KIND_HEADER;
            r.tag         = p_tag;
            r.desc_length = p_len;
            return 1'b1;
         end
         PH_DROP: begin
            use_desc_byte();
            if (p_skip != '0) p_skip = p_skip - 1'b1;
            if (p_skip == '0) p_phase = PH_TAG;
            return 1'b0;
         end
         PH_ES_ID: begin
            if (p_field == '0 && field_overrun(28'd2)) begin
               r.kind = KIND_OVERRUN;
               return 1'b1;
            end
            use_desc_byte();
            p_held0 = {48'd0, p_held0[7:0], b};
            p_field = p_field + 1'b1;
            if (p_field >= ES_ID_BYTES) p_phase = PH_ES_FLAGS;
            return 1'b0;
         end
         PH_ES_FLAGS: begin
            if (field_overrun(28'd1)) begin
               r.kind = KIND_OVERRUN;
               return 1'b1;
            end
            use_desc_byte();
            p_held1    = {56'd0, b};
            r.kind     = KIND_ES;
            r.es_id    = p_held0[15:0];
            r.es_flags = b;
            advance_es_part(ES_STAGE_FLAGS);
            return 1'b1;
         end
         PH_ES_DEP, PH_ES_URL, PH_ES_OCR: begin
            use_desc_byte();
            if (p_skip != '0) p_skip = p_skip - 1'b1;
            if (p_skip == '0) begin
               if (p_phase == PH_ES_DEP)      advance_es_part(ES_STAGE_DEP);
               else if (p_phase == PH_ES_URL) advance_es_part(ES_STAGE_URL);
               else                           advance_es_part(ES_STAGE_OCR);
            end
            return 1'b0;
         end
         PH_ES_URLLEN: begin
            use_desc_byte();
            if (b == 8'd0) begin
               advance_es_part(ES_STAGE_URL);
            end else begin
               p_skip  = b;
               p_phase = PH_ES_URL;
            end
            return 1'b0;
         end
         PH_DEC: begin
            // multi-byte fields are checked on their first byte only
            need = '0;
            if (p_field <= 4'd1) need = 28'd1;
            else if (p_field == 4'd2) need = 28'd3;
            else if (p_field == DEC_HI_FIRST || p_field == DEC_AVG_FIRST) need = 28'd4;
            if (need != '0 && field_overrun(need)) begin
               r.kind = KIND_OVERRUN;
               return 1'b1;
            end
            use_desc_byte();
            if (p_field < DEC_HI_FIRST) p_held0 = (p_held0 << 8) | {56'd0, b};
            else                        p_held1 = (p_held1 << 8) | {56'd0, b};
            if (p_field < DEC_LAST_IDX) begin
               p_field = p_field + 1'b1;
               return 1'b0;
            end
            r.kind        = KIND_DEC;
            r.object_type = p_held0[39:32];
            r.stream_type = p_held0[31:24];
            r.buffer_size = p_held0[23:0];
            r.max_bitrate = p_held1[63:32];
            r.avg_bitrate = p_held1[31:0];
            p_phase       = PH_TAG;
            return 1'b1;
         end
         PH_PAYLOAD: begin
            use_desc_byte();
            r.kind         = KIND_PAYLOAD;
            r.payload_byte = b;
            if (p_left == '0) p_phase = PH_TAG;
            return 1'b1;
         end
         default: begin
            p_phase = PH_TAG;
            return 1'b0;
         end
      endcase
   endfunction

   // expected record for one accepted byte, if the byte gives one
   function automatic bit predict_byte(input logic [7:0] b, input logic restart,
                                       output rsp_fields_type r);
      bit got;
      bit last;
      r = '0;
      if (restart) clear_parse_state();
      if (p_pos >= body_len_cfg) return 1'b0;   // past the body: silent
      last = ({1'b0, p_pos} + 25'd1 == {1'b0, body_len_cfg});
      got  = 1'b0;
      if (!p_halted) got = parse_desc_byte(b, r);
      p_pos = p_pos + 1'b1;
      if (!got) begin
         // the last body byte always reports, as end only if nothing else
         if (!last) return 1'b0;
         r      = '0;
         r.kind = KIND_END;
      end
      r.body_end = last;
      return 1'b1;
   endfunction

   function automatic string field_diffs(input rsp_fields_type e, input rsp_fields_type a);
      string s;
      s = "";
      if (a.kind !== e.kind)                 s = {s, " kind"};
      if (a.tag !== e.tag)                   s = {s, " tag"};
      if (a.desc_length !== e.desc_length)   s = {s, " desc_length"};
      if (a.es_id !== e.es_id)               s = {s, " es_id"};
      if (a.es_flags !== e.es_flags)         s = {s, " es_flags"};
      if (a.object_type !== e.object_type)   s = {s, " object_type"};
      if (a.stream_type !== e.stream_type)   s = {s, " stream_type"};
      if (a.buffer_size !== e.buffer_size)   s = {s, " buffer_size"};
      if (a.max_bitrate !== e.max_bitrate)   s = {s, " max_bitrate"};
      if (a.avg_bitrate !== e.avg_bitrate)   s = {s, " avg_bitrate"};
      if (a.payload_byte !== e.payload_byte) s = {s, " payload_byte"};
      if (a.body_end !== e.body_end)         s = {s, " body_end"};
      return s;
   endfunction

   function automatic void show_result(input string label, input rsp_fields_type r);
      $display("%s kind=%0d tag=%h len=%h id=%h flags=%h", label, r.kind, r.tag,
               r.desc_length, r.es_id, r.es_flags);
      $display("%s obj=%h strm=%h buf=%h max=%h avg=%h pay=%h end=%b", label,
               r.object_type, r.stream_type, r.buffer_size, r.max_bitrate,
               r.avg_bitrate, r.payload_byte, r.body_end);
   endfunction

   // ------------------------------------------------------------------------
   // Scoreboard: predict on each byte transfer, check on each result
   // transfer. Everything is sampled at the rising edge, before the block's
   // own updates of that edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      rsp_fields_type want;
      rsp_fields_type seen;
      string          diffs;
      if (reset) begin
         body_len_cfg = '0;
         clear_parse_state();
         pending_results.delete();
      end else begin
         if (csr_if.valid && csr_if.ready) body_len_cfg = csr_if.body_length;
         if (req_if.valid && req_if.ready) begin
            if (predict_byte(req_if.data_in, req_if.first, want))
               pending_results.push_back(want);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            seen.kind         = kind_type'(rsp_if.kind);
            seen.tag          = rsp_if.tag;
            seen.desc_length  = rsp_if.desc_length;
            seen.es_id        = rsp_if.es_id;
            seen.es_flags     = rsp_if.es_flags;
            seen.object_type  = rsp_if.object_type;
            seen.stream_type  = rsp_if.stream_type;
            seen.buffer_size  = rsp_if.buffer_size;
            seen.max_bitrate  = rsp_if.max_bitrate;
            seen.avg_bitrate  = rsp_if.avg_bitrate;
            seen.payload_byte = rsp_if.payload_byte;
            seen.body_end     = rsp_if.body_end;
            if (pending_results.size() == 0) begin
               failure_count++;
               if (failure_count <= MAX_REPORTS) begin
                  $display("unexpected result at %0t", $time);
                  show_result("  actual  ", seen);
               end
            end else begin
               want  = pending_results.pop_front();
               diffs = field_diffs(want, seen);
               results_checked++;
               if (seen.kind <= KIND_END) kind_hits[seen.kind]++;
               if (diffs != "") begin
                  failure_count++;
                  if (failure_count <= MAX_REPORTS) begin
                     $display("mismatch at %0t:%s", $time, diffs);
                     show_result("  expected", want);
                     show_result("  actual  ", seen);
                  end
               end
            end
         end
      end
   end

   // watchdog: any transfer on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // result side: random stalls, or a solid hold while rsp_hold is set
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Driving tasks. Each is entered right after a rising edge.
   // ------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic restart);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.data_in <= b;
      req_if.first   <= restart;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // drain every expected result, then let silent bytes clear the pipe
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_body_length(input logic [23:0] v);
      wait_idle();
      csr_if.valid       <= 1'b1;
      csr_if.body_length <= v;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      @(posedge clock);
      length_writes++;
   endtask

   // first cut bytes of body_bytes, restart mark on byte zero, then
   // trailing bytes past the body
   task automatic run_body(input int cut, input int extra);
      int i;
      for (i = 0; i < cut; i++) send_byte(body_bytes[i], i == 0);
      repeat (extra) send_byte(8'($urandom), 1'b0);
      bodies_sent++;
   endtask

   task automatic hold_result_channel(input int cycles);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (cycles) @(posedge clock);
      rsp_hold <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Chain generation
   // ------------------------------------------------------------------------
   // length in 7-bit groups; sometimes padded with empty leading groups,
   // and a fourth group may carry a stray more bit
   task automatic push_length(input int n);
      int         groups;
      int         i;
      logic [7:0] g;
      groups = 1;
      while (groups < 4 && (n >> (7 * groups)) != 0) groups++;
      if ($urandom_range(7) == 0) groups = $urandom_range(groups, 4);
      for (i = groups - 1; i >= 0; i--) begin
         g = 8'(n >> (7 * i)) & LEN_GROUP_MASK;
         if (i != 0 || (groups == 4 && $urandom_range(1) == 1)) g[7] = 1'b1;
         body_bytes.push_back(g);
      end
   endtask

   task automatic add_descriptor();
      int         sel;
      int         n;
      int         url_n;
      logic [7:0] flags;
      sel = $urandom_range(99);
      if (sel < 10) begin
         // object descriptor: two id bytes, sometimes too short to drop them
         n = ($urandom_range(3) == 0) ? $urandom_range(3) : 2;
         body_bytes.push_back(TAG_OD);
         push_length(n);
         repeat (n) body_bytes.push_back(8'($urandom));
      end else if (sel < 20) begin
         body_bytes.push_back(TAG_IOD);
         push_length(($urandom_range(3) == 0) ? $urandom_range(12) : 7);
         repeat (IOD_SKIP) body_bytes.push_back(8'($urandom));
      end else if (sel < 40) begin
         // ES descriptor with random optional parts; length may also cover
         // the nested descriptors that follow, or be too short
         flags = 8'($urandom);
         url_n = $urandom_range(6);
         n = 3 + (((flags & ES_FLAG_DEP) != 8'd0) ? 2 : 0)
               + (((flags & ES_FLAG_URL) != 8'd0) ? 1 + url_n : 0)
               + (((flags & ES_FLAG_OCR) != 8'd0) ? 2 : 0);
         body_bytes.push_back(TAG_ES);
         if ($urandom_range(9) == 0) push_length($urandom_range(2));
         else push_length(n + (($urandom_range(1) == 1) ? $urandom_range(20) : 0));
         repeat (2) body_bytes.push_back(8'($urandom));
         body_bytes.push_back(flags);
         if ((flags & ES_FLAG_DEP) != 8'd0) repeat (2) body_bytes.push_back(8'($urandom));
         if ((flags & ES_FLAG_URL) != 8'd0) begin
            body_bytes.push_back(8'(url_n));
            repeat (url_n) body_bytes.push_back(8'($urandom));
         end
         if ((flags & ES_FLAG_OCR) != 8'd0) repeat (2) body_bytes.push_back(8'($urandom));
      end else if (sel < 60) begin
         // decoder config: 13 field bytes; a short length overruns a field
         body_bytes.push_back(TAG_DEC);
         if ($urandom_range(6) == 0) push_length($urandom_range(12));
         else push_length(13 + (($urandom_range(1) == 1) ? $urandom_range(20) : 0));
         repeat (13) body_bytes.push_back(8'($urandom));
      end else if (sel < 92) begin
         n = $urandom_range(10);
         body_bytes.push_back(($urandom_range(1) == 1) ? TAG_DSI : TAG_SL);
         push_length(n);
         repeat (n) body_bytes.push_back(8'($urandom));
      end else if (sel < 95) begin
         // payload with a huge four-group length: runs to the body end
         body_bytes.push_back(($urandom_range(1) == 1) ? TAG_DSI : TAG_SL);
         repeat (3) body_bytes.push_back(8'($urandom) | 8'h80);
         body_bytes.push_back(8'($urandom));
         repeat (8) body_bytes.push_back(8'($urandom));
      end else begin
         body_bytes.push_back(($urandom_range(1) == 1) ? TAG_FORBIDDEN
                                                       : 8'($urandom_range(7, 255)));
         body_bytes.push_back(8'($urandom));
      end
   endtask

   // one body of lim bytes, two if lim is zero; a chain cut where lim falls
   task automatic build_chain(input int lim);
      body_bytes.delete();
      if (lim == 0 || $urandom_range(19) == 0) begin
         repeat ((lim == 0) ? 2 : lim) body_bytes.push_back(8'($urandom));
      end else begin
         while (body_bytes.size() < lim) add_descriptor();
         while (body_bytes.size() > lim) void'(body_bytes.pop_back());
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // empty body, one-byte body, and the largest body length carrying a
   // payload descriptor whose length uses all four groups
   task automatic test_body_length_extremes();
      set_body_length(24'd0);
      body_bytes = '{TAG_ES};
      run_body(body_bytes.size(), 0);
      set_body_length(24'd1);
      body_bytes = '{8'h00};
      run_body(body_bytes.size(), 0);
      set_body_length(24'hFFFFFF);
      body_bytes = '{TAG_DSI, 8'h80, 8'h80, 8'h80, 8'h82, 8'h00, 8'hFF};
      run_body(body_bytes.size(), 0);
   endtask

   task automatic test_unknown_tag();
      set_body_length(24'd3);
      body_bytes = '{8'hFF, 8'h80, 8'h7F};
      run_body(body_bytes.size(), 0);
   endtask

   // decoder config too short for its second field, ES too short for its id
   task automatic test_field_overrun();
      set_body_length(24'd4);
      body_bytes = '{TAG_DEC, 8'h01, 8'h40, 8'h15};
      run_body(body_bytes.size(), 0);
      set_body_length(24'd3);
      body_bytes = '{TAG_ES, 8'h01, 8'h00};
      run_body(body_bytes.size(), 0);
   endtask

   // a tag on the last body byte ends the chain
   task automatic test_chain_end();
      set_body_length(24'd3);
      body_bytes = '{TAG_SL, 8'h00, 8'h07};
      run_body(body_bytes.size(), 0);
   endtask

   // every byte of a long payload gives a result while the result side is
   // held, so the block fills up and stops taking bytes
   task automatic test_result_backpressure();
      sender_idle_pct = 0;
      recv_idle_pct   = 0;
      set_body_length(24'd64);
      body_bytes = '{TAG_DSI, 8'd62};
      repeat (62) body_bytes.push_back(8'($urandom));
      fork
         hold_result_channel(HOLD_CYCLES);
         run_body(body_bytes.size(), 0);
      join
   endtask

   task automatic test_random_chains(input int target, input int tx_idle, input int rx_idle);
      int counted;
      int lim;
      int cut;
      int sel;
      counted         = 0;
      sender_idle_pct = tx_idle;
      recv_idle_pct   = rx_idle;
      while (counted < target) begin
         sel = $urandom_range(99);
         if (sel < 3)      lim = 0;
         else if (sel < 6) lim = 1;
         else if (sel < 9) lim = $urandom_range(60, 130);
         else              lim = $urandom_range(2, 48);
         set_body_length(24'(lim));
         repeat ($urandom_range(2, 5)) begin
            build_chain(lim);
            cut = body_bytes.size();
            // sometimes a new body restarts the parse in mid-chain
            if (lim > 1 && $urandom_range(9) == 0) cut = $urandom_range(1, cut - 1);
            run_body(cut, (lim > 0 && cut == lim && $urandom_range(4) == 0)
                          ? $urandom_range(1, 3) : 0);
            if (lim > 0) counted += cut;
         end
      end
   endtask

   initial begin : main
      req_if.valid       = 1'b0;
      req_if.data_in     = '0;
      req_if.first       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.body_length = '0;
      foreach (kind_hits[k]) kind_hits[k] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct = 20;
      recv_idle_pct   = 87;
      test_body_length_extremes();
      test_unknown_tag();
      test_field_overrun();
      test_chain_end();
      test_result_backpressure();
      test_random_chains(520, 20, 87);
      test_random_chains(520, 87, 20);
      test_random_chains(520, 0, 0);
      wait_idle();

      $display("summary: %0d bytes in %0d bodies, %0d body length writes, %0d results checked",
               bytes_sent, bodies_sent, length_writes, results_checked);
      $display("summary: header %0d, es %0d, dec %0d, payload %0d, unknown %0d, %s %0d, end %0d",
               kind_hits[KIND_HEADER], kind_hits[KIND_ES], kind_hits[KIND_DEC],
               kind_hits[KIND_PAYLOAD], kind_hits[KIND_UNKNOWN], "overrun",
               kind_hits[KIND_OVERRUN], kind_hits[KIND_END]);
      if (failure_count == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
